[rtl/sasf_pkg.sv]
`timescale 1ns / 1ps

package sasf_pkg;

   // payload widths
   localparam int SAMPLE_W = 24;
   localparam int TRACK_W  = 32;
   localparam int FRAC_W   = 8;
   localparam int DIV_W    = 16;
   localparam int QUIET_W  = 7;
   localparam int DRIFT_W  = 16;
   localparam int DCLAMP_W = 13;

   // Q14 coefficients: 0.98 and 0.0125
   localparam int COEF_W = 14;
   localparam logic [COEF_W-1:0] COEF_FAST = 14'd16056;
   localparam logic [COEF_W-1:0] COEF_SLOW = 14'd205;
   localparam int PROD_W = TRACK_W + COEF_W;
   localparam int STEP_W = PROD_W + 1 - COEF_W;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(8192);

   // drift limits in Q7.8
   localparam logic signed [DCLAMP_W-1:0] DRIFT_CLAMP = 13'sd2048;
   localparam logic signed [DRIFT_W-1:0]  DRIFT_LIMIT = 16'sd9728;

   localparam logic [QUIET_W-1:0] QUIET_MAX    = 7'd100;
   localparam logic [QUIET_W-1:0] QUIET_NEEDED = 7'd8;

   localparam logic [DIV_W-1:0] DIV_RESET = 16'd10;

   // radix-4 mean divider: two quotient bits per step
   localparam int DIGIT_W    = 2;
   localparam int MEAN_STEPS = TRACK_W / DIGIT_W;
   localparam int STEP_CNT_W = $clog2(MEAN_STEPS);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_LOAD = 10'b00_0000_0010,
      ST_DIV  = 10'b00_0000_0100,
      ST_DEV  = 10'b00_0000_1000,
      ST_ABS  = 10'b00_0001_0000,
      ST_CMP  = 10'b00_0010_0000,
      ST_MUL  = 10'b00_0100_0000,
      ST_RND  = 10'b00_1000_0000,
      ST_UPD  = 10'b01_0000_0000,
      ST_DONE = 10'b10_0000_0000
   } state_type;

endpackage

[rtl/sasf_window.sv]
`timescale 1ns / 1ps

module sasf_window
   import sasf_pkg::*;
#(
   parameter int WINDOW_LEN = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    shift_en,
   input  logic                                    preload,
   input  logic [SAMPLE_W-1:0]                     sample,
   output logic [SAMPLE_W+$clog2(WINDOW_LEN)-1:0]  sum
);

   localparam int SumW = SAMPLE_W + $clog2(WINDOW_LEN);

   logic [SAMPLE_W-1:0] taps_ff [WINDOW_LEN];
   logic [SumW-1:0]     sum_ff;
   logic [SumW-1:0]     sum_in;

   // running sum: drop the oldest tap, add the new sample; preload fills every tap with it
   always_comb begin
      if (preload) begin
         sum_in = SumW'(sample) * SumW'(WINDOW_LEN);
      end else begin
         sum_in = sum_ff - SumW'(taps_ff[WINDOW_LEN-1]) + SumW'(sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            taps_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (shift_en) begin
         taps_ff[0] <= sample;
         for (int i = 1; i < WINDOW_LEN; i++) begin
            taps_ff[i] <= preload ? sample : taps_ff[i-1];
         end
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

[rtl/sasf_mean_div.sv]
`timescale 1ns / 1ps

module sasf_mean_div
   import sasf_pkg::*;
#(
   parameter int WINDOW_LEN = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [SAMPLE_W+$clog2(WINDOW_LEN)-1:0]  sum,
   output logic                                    busy,
   output logic [TRACK_W-1:0]                      mean
);

   localparam int SumW   = SAMPLE_W + $clog2(WINDOW_LEN);
   localparam int RemW   = $clog2(WINDOW_LEN);
   localparam int TrialW = RemW + DIGIT_W;
   localparam int StepMax = MEAN_STEPS - 1;
   localparam logic [TrialW-1:0] Div1 = TrialW'(WINDOW_LEN);
   localparam logic [TrialW-1:0] Div2 = TrialW'(2 * WINDOW_LEN);
   localparam logic [TrialW-1:0] Div3 = TrialW'(3 * WINDOW_LEN);

   logic                  busy_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic [RemW-1:0]       rem_ff;
   logic [TRACK_W-1:0]    acc_ff;   // dividend bits shift out the top, quotient digits in

   logic [TrialW-1:0]  trial;
   logic [TrialW-1:0]  diff;
   logic [DIGIT_W-1:0] digit;

   always_comb begin
      trial = {rem_ff, acc_ff[TRACK_W-1 -: DIGIT_W]};
      if (trial >= Div3) begin
         digit = 2'd3;
         diff  = trial - Div3;
      end else if (trial >= Div2) begin
         digit = 2'd2;
         diff  = trial - Div2;
      end else if (trial >= Div1) begin
         digit = 2'd1;
         diff  = trial - Div1;
      end else begin
         digit = 2'd0;
         diff  = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(StepMax)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // top bits of the sum are always below WINDOW_LEN, so they seed the remainder
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= sum[SumW-1:SAMPLE_W];
         acc_ff <= {sum[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
      end else if (busy_ff) begin
         rem_ff <= diff[RemW-1:0];
         acc_ff <= {acc_ff[TRACK_W-DIGIT_W-1:0], digit};
      end
   end

   assign busy = busy_ff;
   assign mean = acc_ff;

endmodule

[rtl/scale_adc_stability_filter.sv]
`timescale 1ns / 1ps

// Weigh-cell stability filter. Each transfer on req carries one 24-bit ADC code
// (tuser set preloads the window and the track with it); each produces exactly
// one transfer on rsp with the Q24.8 tracked weight and the stable flag. The
// block handles one sample at a time: the next sample is taken only once the last
// is through, and a back-pressured rsp holds it back. The 16 radix-4 steps
// of the window-mean divider come first, then the deviation, compare, 32x14
// multiply, rounding and update steps. The finished result waits in an output
// register, so the next sample is taken while it is still held. division_size
// is written through csr while the block is idle and resets to 10.

module scale_adc_stability_filter
   import sasf_pkg::*;
#(
   parameter int WINDOW_LEN = 8
) (
   input  logic                clock,
   input  logic                reset,
   // request: tdata = sample[23:0]; tuser = preload
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic                req_tuser,
   // response: tdata = weight_track[31:0]; tuser = stable
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TRACK_W-1:0]  rsp_tdata,
   output logic                rsp_tuser,
   // configuration: division_size
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DIV_W-1:0]    csr_data
);

   localparam int SumW = SAMPLE_W + $clog2(WINDOW_LEN);
   localparam int JumpThrW = DIV_W + 14;
   localparam int DevThrW  = DIV_W + 12;
   localparam int WideW    = TRACK_W + 3;
   localparam logic signed [TRACK_W:0] DevClampHi = (TRACK_W+1)'(DRIFT_CLAMP);
   localparam logic signed [TRACK_W:0] DevClampLo = -(TRACK_W+1)'(DRIFT_CLAMP);

   function automatic logic [JumpThrW-1:0] jump_thr(input logic [DIV_W-1:0] d);
      logic [JumpThrW-1:0] x;
      x = JumpThrW'(d);
      return (x << 13) + (x << 11);      // 40 * 256
   endfunction

   function automatic logic [DevThrW-1:0] dev_thr(input logic [DIV_W-1:0] d);
      logic [DevThrW-1:0] x;
      x = DevThrW'(d);
      return (x << 11) + (x << 9);       // 10 * 256
   endfunction

   state_type state_ff, state_in;

   logic [DIV_W-1:0]    div_ff;
   logic [JumpThrW-1:0] thr_jump_ff;
   logic [DevThrW-1:0]  thr_dev_ff;

   logic [SAMPLE_W-1:0]       sample_ff;
   logic [TRACK_W-1:0]        track_ff;
   logic                      stable_ff;
   logic [QUIET_W-1:0]        quiet_cnt_ff;
   logic signed [DRIFT_W-1:0] drift_ff;

   logic signed [TRACK_W:0]   dev_ff;
   logic signed [TRACK_W:0]   jump_ff;
   logic [TRACK_W-1:0]        dev_mag_ff;
   logic [TRACK_W-1:0]        jump_mag_ff;
   logic                      big_ff;
   logic                      quiet_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [STEP_W-1:0]         step_ff;
   logic signed [DRIFT_W-1:0] drift_cand_ff;
   logic                      exceed_ff;

   logic                rsp_valid_ff;
   logic [TRACK_W-1:0]  rsp_data_ff;
   logic                rsp_user_ff;

   logic                req_xfer;
   logic                csr_xfer;
   logic                rsp_free;
   logic [SumW-1:0]     win_sum;
   logic                div_busy;
   logic [TRACK_W-1:0]  mean;

   logic signed [TRACK_W:0]    dev_in;
   logic signed [TRACK_W:0]    jump_in;
   logic [WideW-1:0]           dev_x5;
   logic [WideW-1:0]           quiet_ref;
   logic [COEF_W-1:0]          coef;
   logic signed [DCLAMP_W-1:0] dclamp;
   logic signed [DRIFT_W:0]    drift_acc;
   logic                       same_sign;
   logic [WideW-1:0]           trk_wide;
   logic [WideW-1:0]           creep_wide;
   logic [TRACK_W-1:0]         creep_val;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   sasf_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_xfer),
      .preload  (req_tuser),
      .sample   (req_tdata),
      .sum      (win_sum)
   );

   sasf_mean_div #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_mean_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_LOAD),
      .sum   (win_sum),
      .busy  (div_busy),
      .mean  (mean)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_DEV;
            end
         end
         ST_DEV:  state_in = ST_ABS;
         ST_ABS:  state_in = ST_CMP;
         ST_CMP:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_RND;
         ST_RND:  state_in = ST_UPD;
         ST_UPD:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration, thresholds kept precomputed
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff      <= DIV_RESET;
         thr_jump_ff <= jump_thr(DIV_RESET);
         thr_dev_ff  <= dev_thr(DIV_RESET);
      end else if (csr_xfer) begin
         div_ff      <= csr_data;
         thr_jump_ff <= jump_thr(csr_data);
         thr_dev_ff  <= dev_thr(csr_data);
      end
   end

   // datapath combinational terms
   always_comb begin
      dev_in   = $signed({1'b0, mean}) - $signed({1'b0, track_ff});
      jump_in  = $signed({1'b0, sample_ff, {FRAC_W{1'b0}}}) - $signed({1'b0, track_ff});
      dev_x5   = {1'b0, dev_mag_ff, 2'b00} + {3'b000, dev_mag_ff};
      quiet_ref = WideW'({div_ff, 10'b0});
      coef     = (!big_ff && stable_ff) ? COEF_SLOW : COEF_FAST;

      if (dev_ff > DevClampHi) begin
         dclamp = DRIFT_CLAMP;
      end else if (dev_ff < DevClampLo) begin
         dclamp = -DRIFT_CLAMP;
      end else begin
         dclamp = dev_ff[DCLAMP_W-1:0];
      end
      same_sign = ((dclamp > 0) && (drift_ff > 0)) || ((dclamp < 0) && (drift_ff < 0));
      drift_acc = (DRIFT_W+1)'(drift_ff) + (DRIFT_W+1)'(dclamp);

      trk_wide = {3'b000, track_ff};
      if (dev_ff[TRACK_W]) begin
         creep_wide = trk_wide - {2'b00, step_ff};
      end else begin
         creep_wide = trk_wide + {2'b00, step_ff};
      end
      if (creep_wide[WideW-1]) begin
         creep_val = '0;
      end else if (|creep_wide[WideW-2:TRACK_W]) begin
         creep_val = '1;
      end else begin
         creep_val = creep_wide[TRACK_W-1:0];
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_ff <= req_tdata;
      end
      case (state_ff)
         ST_DEV: begin
            dev_ff  <= dev_in;
            jump_ff <= jump_in;
         end
         ST_ABS: begin
            dev_mag_ff  <= dev_ff[TRACK_W] ? TRACK_W'(-dev_ff) : dev_ff[TRACK_W-1:0];
            jump_mag_ff <= jump_ff[TRACK_W] ? TRACK_W'(-jump_ff) : jump_ff[TRACK_W-1:0];
         end
         ST_CMP: begin
            big_ff   <= (jump_mag_ff > TRACK_W'(thr_jump_ff))
                        || (dev_mag_ff > TRACK_W'(thr_dev_ff));
            quiet_ff <= dev_x5 < quiet_ref;
         end
         ST_MUL: begin
            prod_ff       <= PROD_W'(dev_mag_ff) * PROD_W'(coef);
            drift_cand_ff <= same_sign ? drift_acc[DRIFT_W-1:0] : DRIFT_W'(dclamp);
         end
         ST_RND: begin
            step_ff   <= STEP_W'(((PROD_W+1)'(prod_ff) + ROUND_HALF) >> COEF_W);
            exceed_ff <= (drift_cand_ff > DRIFT_LIMIT) || (drift_cand_ff < -DRIFT_LIMIT);
         end
         default: begin
         end
      endcase
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= '0;
         stable_ff    <= 1'b0;
         quiet_cnt_ff <= '0;
         drift_ff     <= '0;
      end else if (req_xfer) begin
         if (req_tuser) begin
            track_ff <= {req_tdata, {FRAC_W{1'b0}}};
         end
      end else if (state_ff == ST_UPD) begin
         if (big_ff) begin
            stable_ff <= 1'b0;
            track_ff  <= creep_val;
         end else if (!stable_ff) begin
            drift_ff <= '0;
            if (quiet_cnt_ff > QUIET_NEEDED) begin
               stable_ff <= 1'b1;
               track_ff  <= creep_val;
            end else begin
               track_ff <= mean;
            end
         end else begin
            drift_ff <= drift_cand_ff;
            if (exceed_ff) begin
               track_ff  <= mean;
               stable_ff <= 1'b0;
            end else begin
               track_ff <= creep_val;
            end
         end
         if (quiet_ff) begin
            quiet_cnt_ff <= (quiet_cnt_ff < QUIET_MAX) ? quiet_cnt_ff + 1'b1 : QUIET_MAX;
         end else begin
            quiet_cnt_ff <= '0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_data_ff <= track_ff;
         rsp_user_ff <= stable_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/sasf_checker.sv]
`timescale 1ns / 1ps

module sasf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_valid,
   input logic        csr_ready
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pend_ff;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // samples taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};
      end
   end

   // one sample at a time: input closes straight after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("req_tready still high after a request transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // no response without an outstanding sample
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("response with no sample outstanding");

   // at most one held result plus one in work
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many samples outstanding");

   // settings only change while the input side is open
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> req_tready)
      else $error("configuration transfer while busy");

endmodule

bind scale_adc_stability_filter sasf_checker u_sasf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

[sim/tb_scale_adc_stability_filter.sv]
`timescale 1ns / 1ps

module tb_scale_adc_stability_filter;
   import sasf_pkg::*;

   localparam int FILTER_TAPS = 8;
   localparam int PHASES = 7;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 40;

   // Q14 gains and Q7.8 drift limits
   localparam longint unsigned GAIN_FAST = 16056;
   localparam longint unsigned GAIN_SLOW = 205;
   localparam int DRIFT_STEP_MAX = 8 * 256;
   localparam int DRIFT_TRIP = 38 * 256;
   localparam int QUIET_CAP = 100;
   localparam int QUIET_ARM = 8;

   typedef struct packed {
      logic [SAMPLE_W-1:0] code;
      logic                preload;
   } adc_item_t;

   typedef struct packed {
      logic [TRACK_W-1:0] weight;
      logic               stable;
   } reading_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata = '0;   // sample[23:0]
   logic                req_tuser = 1'b0; // preload
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TRACK_W-1:0]  rsp_tdata;        // weight_track[31:0]
   logic                rsp_tuser;        // stable
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [DIV_W-1:0]    csr_data = '0;

   scale_adc_stability_filter #(
      .WINDOW_LEN(FILTER_TAPS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // filter state as the block should hold it
   logic [SAMPLE_W-1:0] window_q [FILTER_TAPS];
   logic [TRACK_W-1:0]  track_q = '0;
   logic                stable_q = 1'b0;
   logic [QUIET_W-1:0]  quiet_q = '0;
   int                  drift_q = 0;
   logic [DIV_W-1:0]    div_q = 16'd10;

   adc_item_t   pending_samples [$];
   reading_t    expected_readings [$];
   int unsigned items_queued = 0;
   int unsigned items_accepted = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_bus_cycles = 0;
   int unsigned send_idle_pct = 26;
   int unsigned recv_idle_pct = 84;
   logic        req_done = 1'b0;

   initial begin
      for (int n = 0; n < FILTER_TAPS; n++) window_q[n] = '0;
   end

   function automatic logic [TRACK_W-1:0] clip_track(input longint v);
      if (v < 0) return '0;
      if (v > longint'(64'h0000_0000_FFFF_FFFF)) return '1;
      return v[TRACK_W-1:0];
   endfunction

   // track + round-half-away(dev * gain / 2^14), saturated
   function automatic logic [TRACK_W-1:0] nudge(input logic [TRACK_W-1:0] base,
                                                 input longint dev,
                                                 input longint unsigned gain);
      longint unsigned mag;
      longint step;
      mag = (dev < 0) ? -dev : dev;
      step = longint'((mag * gain + 64'd8192) >> 14);
      if (dev < 0) step = -step;
      return clip_track(longint'({32'd0, base}) + step);
   endfunction

   function automatic reading_t advance_filter(input logic [SAMPLE_W-1:0] code,
                                               input logic preload);
      longint unsigned total, dv, mag_dev, mag_jump;
      longint mean, dev, jump;
      int clamped, i;
      reading_t r;
      dv = div_q;
      if (preload) begin
         for (i = 0; i < FILTER_TAPS; i++) window_q[i] = code;
         track_q = {code, 8'h00};
      end
      for (i = FILTER_TAPS - 1; i > 0; i--) window_q[i] = window_q[i-1];
      window_q[0] = code;
      total = 0;
      for (i = 0; i < FILTER_TAPS; i++) total += window_q[i];
      mean = longint'((total << 8) / FILTER_TAPS);
      dev = mean - longint'({32'd0, track_q});
      jump = longint'({32'd0, code, 8'h00}) - longint'({32'd0, track_q});
      mag_dev = (dev < 0) ? -dev : dev;
      mag_jump = (jump < 0) ? -jump : jump;

      if (mag_jump > dv * 10240 || mag_dev > dv * 2560) begin
         stable_q = 1'b0;
         track_q = nudge(track_q, dev, GAIN_FAST);
      end else if (!stable_q) begin
         drift_q = 0;
         if (quiet_q > QUIET_ARM) begin
            stable_q = 1'b1;
            track_q = nudge(track_q, dev, GAIN_FAST);
         end else begin
            track_q = clip_track(mean);
         end
      end else begin
         if (dev > DRIFT_STEP_MAX) clamped = DRIFT_STEP_MAX;
         else if (dev < -DRIFT_STEP_MAX) clamped = -DRIFT_STEP_MAX;
         else clamped = int'(dev);
         // drift only grows while the sign holds
         if ((clamped > 0 && drift_q > 0) || (clamped < 0 && drift_q < 0))
            drift_q += clamped;
         else
            drift_q = clamped;
         if (drift_q > DRIFT_TRIP || drift_q < -DRIFT_TRIP) begin
            track_q = clip_track(mean);
            stable_q = 1'b0;
         end else begin
            track_q = nudge(track_q, dev, GAIN_SLOW);
         end
      end

      if (mag_dev * 5 < dv * 1024)
         quiet_q = (quiet_q >= QUIET_CAP) ? QUIET_W'(QUIET_CAP) : quiet_q + 1'b1;
      else
         quiet_q = '0;

      r.weight = track_q;
      r.stable = stable_q;
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // sender: valid held until the transfer, gaps only between items
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_done) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pending_samples[0].code;
            req_tuser  <= pending_samples[0].preload;
            req_tvalid <= 1'b1;
            void'(pending_samples.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      reading_t want;
      if (reset) begin
         req_done <= 1'b0;
      end else begin
         req_done <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) div_q = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               flag_mismatch($sformatf("unexpected result weight=%h stable=%b",
                                       rsp_tdata, rsp_tuser));
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tdata !== want.weight)
                  flag_mismatch($sformatf("weight_track got %h want %h",
                                          rsp_tdata, want.weight));
               if (rsp_tuser !== want.stable)
                  flag_mismatch($sformatf("stable got %b want %b",
                                          rsp_tuser, want.stable));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(advance_filter(req_tdata, req_tuser));
            items_accepted++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_bus_cycles = 0;
         end else if (++quiet_bus_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic queue_item(input logic [SAMPLE_W-1:0] code, input logic preload);
      adc_item_t it;
      it.code = code;
      it.preload = preload;
      pending_samples.push_back(it);
      items_queued++;
   endtask

   function automatic logic [SAMPLE_W-1:0] clip_code(input int v);
      if (v < 0) return '0;
      if (v > 24'hFF_FFFF) return '1;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic wait_drained();
      while (items_accepted != items_queued || expected_readings.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_division(input logic [DIV_W-1:0] value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly settling runs from a preload: steady, ramping (drift) or with a step
   // jump; the rest raw noise and runs that start without a preload.
   task automatic queue_runs(input int unsigned div, input int unsigned count);
      int unsigned made, len, kind, amp, k;
      int base, ramp, s;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(9);
         len = $urandom_range(12, 30);
         base = int'($urandom_range(24'hFF_FFFF));
         amp = $urandom_range(div / 2);
         ramp = (kind == 5 || kind == 6) ? int'($urandom_range(div / 8 + 1)) : 0;
         if ($urandom_range(1)) ramp = -ramp;
         for (k = 0; k < len; k++) begin
            if (kind == 8) begin
               queue_item(SAMPLE_W'($urandom()), $urandom_range(3) == 0);
            end else begin
               if (kind == 7 && k == len / 2)
                  base += ($urandom_range(1) ? 1 : -1) *
                          int'(div * 41 + $urandom_range(4096));
               base = int'(clip_code(base + ramp));
               s = base + int'($urandom_range(2 * amp)) - int'(amp);
               queue_item(clip_code(s), k == 0 && kind != 9);
            end
         end
         made += len;
      end
   endtask

   initial begin
      logic [DIV_W-1:0] phase_div [PHASES];
      int unsigned phase_len [PHASES];
      int p;

      phase_div[0] = 16'd10;   phase_len[0] = 100;
      phase_div[1] = 16'd1;    phase_len[1] = 100;
      phase_div[2] = 16'hFFFF; phase_len[2] = 100;
      phase_div[3] = DIV_W'($urandom_range(2, 64));     phase_len[3] = 100;
      phase_div[4] = DIV_W'($urandom_range(65, 5000));  phase_len[4] = 100;
      phase_div[5] = 16'd0;    phase_len[5] = 30;
      phase_div[6] = DIV_W'($urandom_range(1, 65535));  phase_len[6] = 100;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed, reset division: stabilise at full scale, drift out, big jump
      queue_item(24'h00_0000, 1'b0);
      queue_item(24'hFF_FFFF, 1'b1);
      repeat (10) queue_item(24'hFF_FFFF, 1'b0);
      repeat (8) queue_item(24'hFF_FFF0, 1'b0);
      queue_item(24'h00_0000, 1'b0);
      queue_item(24'h80_0000, 1'b1);
      wait_drained();

      // zero division: every nonzero deviation is large, nothing is quiet
      write_division(16'd0);
      queue_item(24'h12_3456, 1'b1);
      queue_item(24'h12_3456, 1'b0);
      queue_item(24'h12_3457, 1'b0);
      wait_drained();

      write_division(16'hFFFF);
      queue_item(24'h00_0000, 1'b1);
      queue_item(24'hFF_FFFF, 1'b0);
      queue_item(24'hFF_FFFF, 1'b0);

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         if (p == 2) begin
            send_idle_pct = 84;
            recv_idle_pct = 26;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_division(phase_div[p]);
         queue_runs(phase_div[p], phase_len[p]);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[sim.f]
rtl/sasf_pkg.sv
rtl/sasf_window.sv
rtl/sasf_mean_div.sv
rtl/scale_adc_stability_filter.sv
rtl/sasf_checker.sv
sim/tb_scale_adc_stability_filter.sv
